>>> hw/rtl/tdoa_loc_pkg.sv
// Shared types, constants and a helper function for the four-sensor TDOA locator.
package tdoa_loc_pkg;

	localparam logic [15:0] DIAG_RESET  = 16'd32584;
	localparam logic [15:0] SCALE_RESET = 16'd22282;
	localparam logic [31:0] HALF_ROOT_TWO_Q16 = 32'd46341;
	localparam logic [7:0]  REG_DIAG  = 8'd0;
	localparam logic [7:0]  REG_SCALE = 8'd1;
	localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] POS_MIN = 24'sh800000;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_CALC = 7'b0000010,
		ST_NUM  = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_SQRT = 7'b0010000,
		ST_ROT  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic start;
		logic is_sqrt;
	} iter_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_sts_t;

	// round magnitude * k to nearest, apply sign, clamp to 24 bits
	function automatic logic signed [23:0] rot_sat(input logic [65:0] prod, input logic neg);
		logic [49:0] rnd;
		logic [33:0] r;
		logic signed [23:0] res;
		rnd = prod[49:0] + 50'd32768;
		r = rnd[49:16];
		if (neg) begin
			if (r > 34'd8388608)
				res = POS_MIN;
			else
				res = 24'sd0 - $signed(r[23:0]);
		end else begin
			if (r > 34'd8388607)
				res = POS_MAX;
			else
				res = $signed(r[23:0]);
		end
		return res;
	endfunction

endpackage

>>> hw/rtl/tdoa_loc_mul.sv
// Shared 34x32 multiplier with a registered product.
module tdoa_loc_mul (
	input  logic        clk,
	input  logic [33:0] a,
	input  logic [31:0] b,
	output logic [65:0] prod
);

	logic [65:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= {32'b0, a} * {34'b0, b};
	end

	assign prod = prod_q;

endmodule

>>> hw/rtl/tdoa_loc_iter.sv
// Iterative unit: saturating 97/64-bit restoring divide or 64-bit integer square root.
module tdoa_loc_iter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tdoa_loc_pkg::iter_cmd_t cmd,
	input  logic [32:0]            num_hi,
	input  logic [63:0]            num_lo,
	input  logic [63:0]            den,
	output tdoa_loc_pkg::iter_sts_t sts,
	output logic [63:0]            res
);

	logic        busy_q;
	logic        done_q;
	logic        sqrt_q;
	logic [6:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] lo_q;
	logic [63:0] dvs_q;
	logic [63:0] bit_q;

	logic [64:0] trial;
	logic        ge_div;
	logic [64:0] diff_div;
	logic [63:0] sq_sum;
	logic        ge_sq;

	always_comb begin
		trial    = {rem_q, lo_q[63]};
		ge_div   = trial >= {1'b0, dvs_q};
		diff_div = trial - {1'b0, dvs_q};
		sq_sum   = quo_q + bit_q;
		ge_sq    = rem_q >= sq_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sqrt_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (cmd.start) begin
					sqrt_q <= cmd.is_sqrt;
					if (cmd.is_sqrt) begin
						rem_q  <= num_lo;
						quo_q  <= '0;
						bit_q  <= 64'h4000_0000_0000_0000;
						cnt_q  <= 7'd32;
						busy_q <= 1'b1;
					end else if ({31'b0, num_hi} >= den) begin
						// quotient does not fit: saturate
						quo_q  <= '1;
						done_q <= 1'b1;
					end else begin
						rem_q  <= {31'b0, num_hi};
						lo_q   <= num_lo;
						dvs_q  <= den;
						quo_q  <= '0;
						cnt_q  <= 7'd64;
						busy_q <= 1'b1;
					end
				end
			end else begin
				if (sqrt_q) begin
					if (ge_sq) begin
						rem_q <= rem_q - sq_sum;
						quo_q <= (quo_q >> 1) + bit_q;
					end else begin
						quo_q <= quo_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					rem_q <= ge_div ? diff_div[63:0] : trial[63:0];
					quo_q <= {quo_q[62:0], ge_div};
					lo_q  <= {lo_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign res      = quo_q;

endmodule

>>> hw/rtl/tdoa_four_sensor_locator_unit.sv
// Top level of the four-sensor TDOA locator: sequencer, operand selection and result register.
//
// Input channel: in_valid / in_stall with arrival_one .. arrival_four. A word is
// taken when in_valid is high and in_stall low; in_stall stays high from then
// until the result has been loaded into the output register.
// Output channel: out_valid / out_stall with pos_x, pos_y, updated. Exactly one
// output word follows each input word. The output register holds its word while
// out_stall is high; the next input word may be taken while it waits.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Index 0 is the diagonal length, index 1 the sound speed scale,
// other indexes are dropped. Write only while no word is in flight.
// When b is imaginary the sequencer leaves the multiplier steps early for the
// output register, and again when the intersection is degenerate. A full
// solution runs two divisions and two square roots on the shared divide/root
// unit, steps around the shared 34x32 multiplier, then loads the output
// register; a division whose quotient saturates finishes without iterating.
// A stalled output word delays the load of the next result.
// Reset clears the held position to zero and loads the default registers.
module tdoa_four_sensor_locator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        arrival_one,
	input  logic [15:0]        arrival_two,
	input  logic [15:0]        arrival_three,
	input  logic [15:0]        arrival_four,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] pos_x,
	output logic signed [23:0] pos_y,
	output logic               updated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	tdoa_loc_pkg::state_t    state_q;
	logic [3:0]              step_q;
	logic                    pass_q;
	logic [15:0]             diag_q;
	logic [15:0]             scale_q;
	logic signed [23:0]      last_x_q;
	logic signed [23:0]      last_y_q;
	logic                    out_valid_q;
	logic signed [23:0]      pos_x_q;
	logic signed [23:0]      pos_y_q;
	logic                    updated_q;
	logic                    upd_q;

	logic [15:0] m1_q, m2_q;
	logic        n1_q, n2_q;
	logic [22:0] a1_q, a2_q;
	logic [31:0] csq_q;
	logic [45:0] u_q, v_q;
	logic [31:0] p_q, q_q;
	logic [63:0] den_q;
	logic [63:0] uq_q, vp_q;
	logic [96:0] num_q;
	logic [63:0] dxs_q, dys_q;
	logic [31:0] dx_q, dy_q;

	logic [33:0] mul_a;
	logic [31:0] mul_b;
	logic [65:0] prod;

	tdoa_loc_pkg::iter_cmd_t iter_cmd;
	tdoa_loc_pkg::iter_sts_t iter_sts;
	logic [63:0]             iter_lo;
	logic [63:0]             iter_res;

	logic        in_acc;
	logic        out_free;
	logic        b_imag;
	logic [63:0] w_sel;
	logic [32:0] s_sum;
	logic signed [33:0] sdx, sx, sy;
	logic [33:0] mag_x, mag_y;

	assign in_stall  = (state_q != tdoa_loc_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		b_imag = (u_q > {14'b0, csq_q}) || (v_q > {14'b0, csq_q});
		w_sel  = pass_q ? vp_q : uq_q;
		s_sum  = pass_q ? ({1'b0, u_q[31:0]} + {1'b0, q_q})
		                : ({1'b0, v_q[31:0]} + {1'b0, p_q});
		sdx    = n1_q ? (34'sd0 - $signed({2'b0, dx_q})) : $signed({2'b0, dx_q});
		// x takes dy against the sign of the second difference, y with it
		sx     = n2_q ? (sdx + $signed({2'b0, dy_q})) : (sdx - $signed({2'b0, dy_q}));
		sy     = n2_q ? (sdx - $signed({2'b0, dy_q})) : (sdx + $signed({2'b0, dy_q}));
		mag_x  = sx[33] ? 34'(-sx) : 34'(sx);
		mag_y  = sy[33] ? 34'(-sy) : 34'(sy);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			tdoa_loc_pkg::ST_CALC: begin
				case (step_q)
					4'd0: begin
						mul_a = {18'b0, m1_q};
						mul_b = {16'b0, scale_q};
					end
					4'd1: begin
						mul_a = {18'b0, m2_q};
						mul_b = {16'b0, scale_q};
					end
					4'd2: begin
						mul_a = {18'b0, diag_q};
						mul_b = {16'b0, diag_q};
					end
					4'd3: begin
						mul_a = {11'b0, a1_q};
						mul_b = {9'b0, a1_q};
					end
					4'd4: begin
						mul_a = {11'b0, a2_q};
						mul_b = {9'b0, a2_q};
					end
					4'd7: begin
						mul_a = {2'b0, p_q};
						mul_b = q_q;
					end
					4'd8: begin
						mul_a = {2'b0, u_q[31:0]};
						mul_b = v_q[31:0];
					end
					4'd9: begin
						mul_a = {2'b0, u_q[31:0]};
						mul_b = q_q;
					end
					4'd10: begin
						mul_a = {2'b0, v_q[31:0]};
						mul_b = p_q;
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			tdoa_loc_pkg::ST_NUM: begin
				if (step_q == 4'd0) begin
					mul_a = {2'b0, w_sel[31:0]};
					mul_b = s_sum[31:0];
				end else if (step_q == 4'd1) begin
					mul_a = {2'b0, w_sel[63:32]};
					mul_b = s_sum[31:0];
				end
			end
			tdoa_loc_pkg::ST_ROT: begin
				mul_a = (step_q == 4'd0) ? mag_x : mag_y;
				mul_b = tdoa_loc_pkg::HALF_ROOT_TWO_Q16;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		iter_cmd.start   = 1'b0;
		iter_cmd.is_sqrt = 1'b0;
		iter_lo          = num_q[63:0];
		case (state_q)
			tdoa_loc_pkg::ST_NUM: begin
				iter_cmd.start = (step_q == 4'd4);
			end
			tdoa_loc_pkg::ST_DIV: begin
				iter_cmd.start   = iter_sts.done && pass_q;
				iter_cmd.is_sqrt = 1'b1;
				iter_lo          = dxs_q;
			end
			tdoa_loc_pkg::ST_SQRT: begin
				iter_cmd.start   = iter_sts.done && !pass_q;
				iter_cmd.is_sqrt = 1'b1;
				iter_lo          = dys_q;
			end
			default: begin
				iter_cmd.start = 1'b0;
			end
		endcase
	end

	tdoa_loc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	tdoa_loc_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (iter_cmd),
		.num_hi (num_q[96:64]),
		.num_lo (iter_lo),
		.den    (den_q),
		.sts    (iter_sts),
		.res    (iter_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tdoa_loc_pkg::ST_IDLE;
			step_q      <= '0;
			pass_q      <= 1'b0;
			diag_q      <= tdoa_loc_pkg::DIAG_RESET;
			scale_q     <= tdoa_loc_pkg::SCALE_RESET;
			last_x_q    <= '0;
			last_y_q    <= '0;
			out_valid_q <= 1'b0;
			upd_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == tdoa_loc_pkg::REG_DIAG)
					diag_q <= cfg_data;
				else if (cfg_index == tdoa_loc_pkg::REG_SCALE)
					scale_q <= cfg_data;
			end
			if (state_q == tdoa_loc_pkg::ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				tdoa_loc_pkg::ST_IDLE: begin
					if (in_acc) begin
						n1_q    <= arrival_three < arrival_one;
						n2_q    <= arrival_four < arrival_two;
						m1_q    <= (arrival_three < arrival_one) ? (arrival_one - arrival_three)
						                                         : (arrival_three - arrival_one);
						m2_q    <= (arrival_four < arrival_two) ? (arrival_two - arrival_four)
						                                        : (arrival_four - arrival_two);
						upd_q   <= 1'b0;
						step_q  <= '0;
						state_q <= tdoa_loc_pkg::ST_CALC;
					end
				end
				tdoa_loc_pkg::ST_CALC: begin
					step_q <= step_q + 4'd1;
					case (step_q)
						4'd1: a1_q <= prod[31:9];
						4'd2: a2_q <= prod[31:9];
						4'd3: csq_q <= prod[31:0];
						4'd4: u_q <= prod[45:0];
						4'd5: v_q <= prod[45:0];
						4'd6: begin
							if (b_imag)
								state_q <= tdoa_loc_pkg::ST_FIN;
							p_q <= csq_q - u_q[31:0];
							q_q <= csq_q - v_q[31:0];
						end
						4'd8: den_q <= prod[63:0];
						4'd9: begin
							// drop degenerate intersections
							if (den_q <= prod[63:0])
								state_q <= tdoa_loc_pkg::ST_FIN;
							den_q <= den_q - prod[63:0];
						end
						4'd10: uq_q <= prod[63:0];
						4'd11: begin
							vp_q    <= prod[63:0];
							pass_q  <= 1'b0;
							step_q  <= '0;
							state_q <= tdoa_loc_pkg::ST_NUM;
						end
						default: begin
						end
					endcase
				end
				tdoa_loc_pkg::ST_NUM: begin
					step_q <= step_q + 4'd1;
					case (step_q)
						4'd1: num_q <= {33'b0, prod[63:0]};
						4'd2: num_q <= num_q + {1'b0, prod[63:0], 32'b0};
						4'd3: begin
							// top bit of the 33-bit sum weighs 2^32
							if (s_sum[32])
								num_q <= num_q + {1'b0, w_sel, 32'b0};
						end
						4'd4: state_q <= tdoa_loc_pkg::ST_DIV;
						default: begin
						end
					endcase
				end
				tdoa_loc_pkg::ST_DIV: begin
					if (iter_sts.done) begin
						if (!pass_q) begin
							dxs_q   <= iter_res;
							pass_q  <= 1'b1;
							step_q  <= '0;
							state_q <= tdoa_loc_pkg::ST_NUM;
						end else begin
							// square root of the x term starts here
							dys_q   <= iter_res;
							pass_q  <= 1'b0;
							state_q <= tdoa_loc_pkg::ST_SQRT;
						end
					end
				end
				tdoa_loc_pkg::ST_SQRT: begin
					if (iter_sts.done) begin
						if (!pass_q) begin
							dx_q   <= iter_res[31:0];
							pass_q <= 1'b1;
						end else begin
							dy_q    <= iter_res[31:0];
							step_q  <= '0;
							state_q <= tdoa_loc_pkg::ST_ROT;
						end
					end
				end
				tdoa_loc_pkg::ST_ROT: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd1)
						last_x_q <= tdoa_loc_pkg::rot_sat(prod, sx[33]);
					if (step_q == 4'd2) begin
						last_y_q <= tdoa_loc_pkg::rot_sat(prod, sy[33]);
						upd_q    <= 1'b1;
						state_q  <= tdoa_loc_pkg::ST_FIN;
					end
				end
				tdoa_loc_pkg::ST_FIN: begin
					if (out_free) begin
						pos_x_q   <= last_x_q;
						pos_y_q   <= last_y_q;
						updated_q <= upd_q;
						state_q   <= tdoa_loc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tdoa_loc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign updated   = updated_q;

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the four-sensor TDOA locator unit.
`timescale 1ns / 1ps

module tb_top;

	typedef struct {
		logic [15:0] t1, t2, t3, t4;
		logic        known;
		logic signed [23:0] ex, ey;
		logic        eu;
	} event_row_t;

	typedef struct {
		logic signed [23:0] x, y;
		logic               upd;
	} fix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_stall;
	logic [15:0] arrival_one = '0, arrival_two = '0, arrival_three = '0, arrival_four = '0;
	logic out_valid, out_stall = 1'b0;
	logic signed [23:0] pos_x, pos_y;
	logic updated;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	tdoa_four_sensor_locator_unit u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of registers and held position
	logic [15:0] diag_len, sound_scale;
	logic signed [23:0] held_x, held_y;
	fix_t fix_queue[$];
	int errors = 0, fixes_seen = 0, updates_seen = 0, events_sent = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	logic hold_off = 1'b0;

	function automatic logic [63:0] root64(input logic [63:0] x);
		logic [63:0] res, bitv;
		res = '0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] quot_sat(input logic [127:0] num, input logic [63:0] den);
		logic [127:0] q;
		q = num / {64'd0, den};
		return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
	endfunction

	function automatic logic signed [23:0] rotate_coord(input logic [63:0] p, input logic pn,
			input logic [63:0] q, input logic qn);
		logic signed [65:0] s;
		logic [65:0] mag;
		logic [97:0] r;
		s = (pn ? -$signed({2'b0, p}) : $signed({2'b0, p}))
			+ (qn ? -$signed({2'b0, q}) : $signed({2'b0, q}));
		mag = s < 0 ? -s : s;
		r = ({32'd0, mag} * 98'd46341 + 98'd32768) >> 16;
		if (s < 0)
			return r > 98'd8388608 ? tdoa_loc_pkg::POS_MIN : 24'sd0 - $signed(r[23:0]);
		return r > 98'd8388607 ? tdoa_loc_pkg::POS_MAX : $signed(r[23:0]);
	endfunction

	function automatic fix_t locate(input logic [15:0] t1, t2, t3, t4);
		fix_t f;
		logic signed [17:0] d1, d2;
		logic [63:0] m1, m2, a1, a2, u, v, csq, p, q, bb, aa, dx, dy;
		d1 = $signed({2'b0, t3}) - $signed({2'b0, t1});
		d2 = $signed({2'b0, t4}) - $signed({2'b0, t2});
		m1 = 64'(d1 < 0 ? -d1 : d1);
		m2 = 64'(d2 < 0 ? -d2 : d2);
		a1 = (m1 * 64'(sound_scale)) >> 9;
		a2 = (m2 * 64'(sound_scale)) >> 9;
		u = a1 * a1;
		v = a2 * a2;
		csq = 64'(diag_len) * 64'(diag_len);
		f.upd = 1'b0;
		if (u <= csq && v <= csq) begin
			p = csq - u;
			q = csq - v;
			bb = p * q;
			aa = u * v;
			if (bb > aa) begin
				dx = root64(quot_sat({64'd0, u * q} * {64'd0, v + p}, bb - aa));
				dy = root64(quot_sat({64'd0, v * p} * {64'd0, u + q}, bb - aa));
				held_x = rotate_coord(dx, d1 < 0, dy, !(d2 < 0));
				held_y = rotate_coord(dx, d1 < 0, dy, d2 < 0);
				f.upd = 1'b1;
			end
		end
		f.x = held_x;
		f.y = held_y;
		return f;
	endfunction

	// output side: check each word against the oldest expectation
	always @(posedge clk) begin
		fix_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (fix_queue.size() == 0) begin
				$error("unexpected output word x=%0d y=%0d", pos_x, pos_y);
				errors++;
			end else begin
				e = fix_queue.pop_front();
				fixes_seen++;
				if (updated) updates_seen++;
				if (pos_x !== e.x) begin
					$error("pos_x expected %0d actual %0d", e.x, pos_x);
					errors++;
				end
				if (pos_y !== e.y) begin
					$error("pos_y expected %0d actual %0d", e.y, pos_y);
					errors++;
				end
				if (updated !== e.upd) begin
					$error("updated expected %0b actual %0b", e.upd, updated);
					errors++;
				end
			end
		end
		out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
	end

	// one register write; cfg_valid is dropped again before returning
	task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == tdoa_loc_pkg::REG_DIAG) diag_len = val;
		else if (idx == tdoa_loc_pkg::REG_SCALE) sound_scale = val;
		@(posedge clk);
	endtask

	// offer one event, hold it until taken, then predict
	task automatic send_event(input event_row_t r);
		fix_t f;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		arrival_one <= r.t1;
		arrival_two <= r.t2;
		arrival_three <= r.t3;
		arrival_four <= r.t4;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		f = locate(r.t1, r.t2, r.t3, r.t4);
		if (r.known) begin
			f.x = r.ex;
			f.y = r.ey;
			f.upd = r.eu;
		end
		fix_queue.push_back(f);
		events_sent++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (fix_queue.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic event_row_t mk(input logic [15:0] a, b, c, d);
		event_row_t r;
		r.t1 = a; r.t2 = b; r.t3 = c; r.t4 = d;
		r.known = 1'b0;
		r.ex = '0; r.ey = '0; r.eu = 1'b0;
		return r;
	endfunction

	function automatic event_row_t mk_held(input logic [15:0] a, b, c, d,
			input logic signed [23:0] x, y);
		event_row_t r;
		r = mk(a, b, c, d);
		r.known = 1'b1;
		r.ex = x; r.ey = y; r.eu = 1'b0;
		return r;
	endfunction

	// random event: diffs up to spread, with random signs
	function automatic event_row_t rand_event(input int spread);
		logic [15:0] base1, base2;
		int s1, s2;
		base1 = 16'($urandom);
		base2 = 16'($urandom);
		s1 = $urandom_range(spread);
		s2 = $urandom_range(spread);
		return mk(base1, base2, 16'(base1 + ($urandom_range(1) ? s1 : -s1)),
			16'(base2 + ($urandom_range(1) ? s2 : -s2)));
	endfunction

	event_row_t directed[$];

	initial begin
		event_row_t r;
		int phase;
		diag_len = tdoa_loc_pkg::DIAG_RESET;
		sound_scale = tdoa_loc_pkg::SCALE_RESET;
		held_x = '0;
		held_y = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// held position after reset is zero; imaginary b and extremes hold it
		directed.push_back(mk_held(16'd0, 16'd0, 16'hFFFF, 16'd0, 24'sd0, 24'sd0));
		directed.push_back(mk_held(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 24'sd0, 24'sd0));
		directed.push_back(mk(16'd0, 16'd0, 16'd0, 16'd0));
		directed.push_back(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		directed.push_back(mk(16'd100, 16'd200, 16'd150, 16'd260));
		directed.push_back(mk(16'd150, 16'd260, 16'd100, 16'd200));
		directed.push_back(mk(16'd100, 16'd260, 16'd150, 16'd200));
		directed.push_back(mk(16'd150, 16'd200, 16'd100, 16'd260));
		directed.push_back(mk(16'd500, 16'd500, 16'd500, 16'd700));
		directed.push_back(mk(16'd500, 16'd700, 16'd500, 16'd500));
		directed.push_back(mk(16'd0, 16'd0, 16'd1700, 16'd1700));
		directed.push_back(mk(16'd0, 16'd0, 16'd1690, 16'd0));
		directed.push_back(mk(16'h5555, 16'hAAAA, 16'h5580, 16'hAA00));
		directed.push_back(mk(16'd0, 16'd0, 16'd1000, 16'd1000));
		foreach (directed[i]) send_event(directed[i]);
		drain();

		// zero diagonal: no event gives a new fix; then extreme registers
		write_reg(tdoa_loc_pkg::REG_DIAG, 16'd0);
		send_event(mk(16'd10, 16'd20, 16'd10, 16'd20));
		send_event(mk(16'd10, 16'd20, 16'd30, 16'd5));
		drain();
		write_reg(tdoa_loc_pkg::REG_DIAG, 16'hFFFF);
		write_reg(tdoa_loc_pkg::REG_SCALE, 16'hFFFF);
		write_reg(8'd7, 16'h1234);
		send_event(mk(16'd0, 16'd0, 16'd0, 16'd0));
		send_event(mk(16'd0, 16'd0, 16'hFFFF, 16'd0));
		send_event(mk(16'd0, 16'd0, 16'd511, 16'd0));
		send_event(mk(16'd0, 16'd0, 16'd1, 16'd2));
		send_event(mk(16'd0, 16'd0, 16'd200, 16'd1));
		drain();
		write_reg(tdoa_loc_pkg::REG_SCALE, 16'd0);
		send_event(mk(16'd0, 16'd9, 16'hFFFF, 16'd3));
		drain();
		write_reg(tdoa_loc_pkg::REG_SCALE, 16'd1);
		send_event(mk(16'hFFFF, 16'hFFFF, 16'd0, 16'd0));
		drain();

		// random part across register settings and idling mixes
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 72; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 72; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			case (phase)
				0: begin
					write_reg(tdoa_loc_pkg::REG_DIAG, tdoa_loc_pkg::DIAG_RESET);
					write_reg(tdoa_loc_pkg::REG_SCALE, tdoa_loc_pkg::SCALE_RESET);
				end
				4: begin
					write_reg(tdoa_loc_pkg::REG_DIAG, 16'($urandom));
					write_reg(tdoa_loc_pkg::REG_SCALE, 16'($urandom));
				end
				6: begin
					write_reg(tdoa_loc_pkg::REG_DIAG, 16'hFFFF);
					write_reg(tdoa_loc_pkg::REG_SCALE, 16'd600);
				end
				7: begin
					write_reg(tdoa_loc_pkg::REG_DIAG, 16'd300);
					write_reg(tdoa_loc_pkg::REG_SCALE, 16'hFFFF);
				end
				default: ;
			endcase
			if (phase == 2) begin
				// long receiver hold-off while events keep coming
				fork
					begin
						hold_off <= 1'b1;
						repeat (2000) @(posedge clk);
						hold_off <= 1'b0;
					end
				join_none
			end
			repeat (180) begin
				case ($urandom_range(9))
					0: r = mk(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
					1: r = rand_event(65535);
					2: r = rand_event(20);
					default: r = rand_event(1000);
				endcase
				send_event(r);
			end
			drain();
		end

		$display("Sent %0d events, checked %0d positions (%0d new fixes).",
			events_sent, fixes_seen, updates_seen);
		$display("Covered register extremes, degenerate geometry and all idle/stall mixes.");
		if (errors == 0 && fix_queue.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/tdoa_loc_pkg.sv
hw/rtl/tdoa_loc_mul.sv
hw/rtl/tdoa_loc_iter.sv
hw/rtl/tdoa_four_sensor_locator_unit.sv
bench/tb_top.sv
